>>> design/j1939_engine_frame_decoder_defines.svh
// ----------------------------------------------------------------------------
// J1939 engine frame decoder assertion macros
// Concurrent check wrappers on clk and rst; empty bodies when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef J1939_ENGINE_FRAME_DECODER_DEFINES_SVH
`define J1939_ENGINE_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define JEFD_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// next-cycle implication
`define JEFD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define JEFD_ASSERT_SAME(label, pre, post, msg)
`define JEFD_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

>>> design/jefd_pkg.sv
// ----------------------------------------------------------------------------
// J1939 engine frame decoder package
// Shared types, codes and reset values for the decoder front, queues and back.
// ----------------------------------------------------------------------------
package jefd_pkg;

  // queue depths
  localparam int CMD_DEPTH_DEF = 2;
  localparam int RES_DEPTH_DEF = 4;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PGN_ENGINE_CTRL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PGN_ENGINE_TEMP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PGN_FLUID_PRESS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PGN_DIAG_ACTIVE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PGN_VEHICLE_POWER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PGN_ENGINE_HOURS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_STEP_LIMIT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OIL_TEMP_STEP_LIMIT = 3'd7;

  // register reset values
  localparam logic [15:0] PGN_ENGINE_CTRL_RST     = 16'd61444;
  localparam logic [15:0] PGN_ENGINE_TEMP_RST     = 16'd65262;
  localparam logic [15:0] PGN_FLUID_PRESS_RST     = 16'd65263;
  localparam logic [15:0] PGN_DIAG_ACTIVE_RST     = 16'd65226;
  localparam logic [15:0] PGN_VEHICLE_POWER_RST   = 16'd65271;
  localparam logic [15:0] PGN_ENGINE_HOURS_RST    = 16'd65253;
  localparam logic [15:0] SPEED_STEP_LIMIT_RST    = 16'(750 * 8);
  localparam logic [15:0] OIL_TEMP_STEP_LIMIT_RST = 16'(5 * 32);

  // PDU2 frames start at this PF
  localparam logic [7:0] PF_PDU2_MIN = 8'd240;

  // result kinds
  localparam logic KIND_SENSOR = 1'b0;
  localparam logic KIND_CODE   = 1'b1;

  // sensor identifiers
  localparam logic [2:0] SID_SPEED    = 3'd0;
  localparam logic [2:0] SID_COOLANT  = 3'd1;
  localparam logic [2:0] SID_OIL_TEMP = 3'd2;
  localparam logic [2:0] SID_OIL_PRES = 3'd3;
  localparam logic [2:0] SID_BATTERY  = 3'd4;
  localparam logic [2:0] SID_HOURS    = 3'd5;

  // frame classes decided by the front
  typedef enum logic [2:0] {
    OP_SPEED,
    OP_TEMP,
    OP_PRESS,
    OP_DIAG,
    OP_POWER,
    OP_HOURS
  } op_t;

  // matched frame waiting for the back
  typedef struct packed {
    op_t        op;
    logic [7:0] b5;
    logic [7:0] b4;
    logic [7:0] b3;
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [2:0]  sensor_id;
    logic [31:0] reading;
    logic [18:0] fault_spn;
    logic [4:0]  fault_fmi;
    logic [6:0]  fault_count;
    logic        fault_seen;
    logic        last;
  } res_t;

  // PGN match registers
  typedef struct packed {
    logic [15:0] engine_ctrl;
    logic [15:0] engine_temp;
    logic [15:0] fluid_press;
    logic [15:0] diag_active;
    logic [15:0] vehicle_power;
    logic [15:0] engine_hours;
  } pgn_cfg_t;

  // step limit registers
  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] oil_temp;
  } limit_cfg_t;

  // up to two results written by the back in one cycle
  typedef struct packed {
    logic [1:0] n;
    res_t       first;
    res_t       second;
  } res_push_t;

  // command queue status
  typedef struct packed {
    logic full;
    logic nonempty;
  } cq_status_t;

  // result queue status
  typedef struct packed {
    logic room_two;
    logic nonempty;
  } rq_status_t;

endpackage

>>> design/j1939_engine_frame_decoder.sv
// ----------------------------------------------------------------------------
// J1939 engine frame decoder
// Matches extended CAN frames to engine PGNs and reports changed readings
// and active trouble codes through a result queue.
// ----------------------------------------------------------------------------
// A frame is taken in every cycle while full is low. The front classifies it
// in the cycle it arrives and parks it in a command queue; the back executes
// one command per cycle while the result queue has room for two items, and a
// result is visible once registered in the result queue. Results leave one
// per cycle while pop is high, so an engine temperature frame that changes
// both coolant and oil temperature gives two items; that output port sets
// the sustained rate when such frames follow each other. Frames whose PGN
// matches no register are accepted and produce nothing. The configuration
// port is always ready and must only be written while idle.
// ----------------------------------------------------------------------------
`include "j1939_engine_frame_decoder_defines.svh"

module j1939_engine_frame_decoder #(
  parameter int CMD_DEPTH = jefd_pkg::CMD_DEPTH_DEF,
  parameter int RES_DEPTH = jefd_pkg::RES_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // frame input
  input  logic                           push,
  output logic                           full,
  input  logic [28:0]                    frame_id,
  input  logic [7:0]                     byte0,
  input  logic [7:0]                     byte1,
  input  logic [7:0]                     byte2,
  input  logic [7:0]                     byte3,
  input  logic [7:0]                     byte4,
  input  logic [7:0]                     byte5,
  input  logic [7:0]                     byte6,
  input  logic [7:0]                     byte7,
  // result output
  output logic                           empty,
  input  logic                           pop,
  output logic                           kind,
  output logic [2:0]                     sensor_id,
  output logic [31:0]                    reading,
  output logic [18:0]                    fault_spn,
  output logic [4:0]                     fault_fmi,
  output logic [6:0]                     fault_count,
  output logic                           fault_seen,
  output logic                           last,
  // configuration write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jefd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  jefd_pkg::pgn_cfg_t   pgn_cfg;
  jefd_pkg::limit_cfg_t limits;
  jefd_pkg::cmd_t       front_cmd;
  jefd_pkg::cmd_t       cmd_head;
  jefd_pkg::cq_status_t cq_status;
  jefd_pkg::rq_status_t rq_status;
  jefd_pkg::res_push_t  res_push;
  jefd_pkg::res_t       res_head;
  logic                 in_accept;
  logic                 q_push;
  logic                 cmd_pop;
  logic                 out_accept;

  // handshakes
  assign cfg_ready  = 1'b1;
  assign full       = cq_status.full;
  assign in_accept  = push && !cq_status.full;
  assign empty      = !rq_status.nonempty;
  assign out_accept = pop && rq_status.nonempty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pgn_cfg.engine_ctrl   <= jefd_pkg::PGN_ENGINE_CTRL_RST;
      pgn_cfg.engine_temp   <= jefd_pkg::PGN_ENGINE_TEMP_RST;
      pgn_cfg.fluid_press   <= jefd_pkg::PGN_FLUID_PRESS_RST;
      pgn_cfg.diag_active   <= jefd_pkg::PGN_DIAG_ACTIVE_RST;
      pgn_cfg.vehicle_power <= jefd_pkg::PGN_VEHICLE_POWER_RST;
      pgn_cfg.engine_hours  <= jefd_pkg::PGN_ENGINE_HOURS_RST;
      limits.speed          <= jefd_pkg::SPEED_STEP_LIMIT_RST;
      limits.oil_temp       <= jefd_pkg::OIL_TEMP_STEP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jefd_pkg::REG_PGN_ENGINE_CTRL:     pgn_cfg.engine_ctrl   <= cfg_data;
        jefd_pkg::REG_PGN_ENGINE_TEMP:     pgn_cfg.engine_temp   <= cfg_data;
        jefd_pkg::REG_PGN_FLUID_PRESS:     pgn_cfg.fluid_press   <= cfg_data;
        jefd_pkg::REG_PGN_DIAG_ACTIVE:     pgn_cfg.diag_active   <= cfg_data;
        jefd_pkg::REG_PGN_VEHICLE_POWER:   pgn_cfg.vehicle_power <= cfg_data;
        jefd_pkg::REG_PGN_ENGINE_HOURS:    pgn_cfg.engine_hours  <= cfg_data;
        jefd_pkg::REG_SPEED_STEP_LIMIT:    limits.speed          <= cfg_data;
        jefd_pkg::REG_OIL_TEMP_STEP_LIMIT: limits.oil_temp       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // classify incoming frames
  jefd_front u_front (
    .accept   (in_accept),
    .frame_id (frame_id),
    .byte0    (byte0),
    .byte1    (byte1),
    .byte2    (byte2),
    .byte3    (byte3),
    .byte4    (byte4),
    .byte5    (byte5),
    .pgn_cfg  (pgn_cfg),
    .q_push   (q_push),
    .cmd      (front_cmd)
  );

  // hold classified frames
  jefd_cmd_queue #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (front_cmd),
    .pop    (cmd_pop),
    .rdata  (cmd_head),
    .status (cq_status)
  );

  // execute commands
  jefd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cq_status.nonempty),
    .cmd       (cmd_head),
    .room_two  (rq_status.room_two),
    .limits    (limits),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push)
  );

  // hold result items
  jefd_result_queue #(
    .DEPTH (RES_DEPTH)
  ) u_result_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .pop      (out_accept),
    .head     (res_head),
    .status   (rq_status)
  );

  // drive result ports
  assign kind        = res_head.kind;
  assign sensor_id   = res_head.sensor_id;
  assign reading     = res_head.reading;
  assign fault_spn   = res_head.fault_spn;
  assign fault_fmi   = res_head.fault_fmi;
  assign fault_count = res_head.fault_count;
  assign fault_seen  = res_head.fault_seen;
  assign last        = res_head.last;

  // checks
  `JEFD_ASSERT_SAME(a_diag_one_result, cmd_pop && cmd_head.op == jefd_pkg::OP_DIAG, res_push.n == 2'd1, "diagnostic command did not give exactly one item")
  `JEFD_ASSERT_NEXT(a_push_shows_item, res_push.n != 2'd0, !empty, "result queue empty after a push")
  `JEFD_ASSERT_SAME(a_seen_with_spn, !empty && kind == jefd_pkg::KIND_CODE && fault_spn != 19'd0, fault_seen, "nonzero SPN shown without seen flag")

endmodule

>>> design/jefd_front.sv
// ----------------------------------------------------------------------------
// J1939 frame classifier
// Forms the PGN from the identifier and matches it against the PGN registers.
// ----------------------------------------------------------------------------
module jefd_front (
  input  logic               accept,
  input  logic [28:0]        frame_id,
  input  logic [7:0]         byte0,
  input  logic [7:0]         byte1,
  input  logic [7:0]         byte2,
  input  logic [7:0]         byte3,
  input  logic [7:0]         byte4,
  input  logic [7:0]         byte5,
  input  jefd_pkg::pgn_cfg_t pgn_cfg,
  output logic               q_push,
  output jefd_pkg::cmd_t     cmd
);

  logic [7:0]  pf;
  logic [7:0]  ps;
  logic [15:0] pgn;
  logic        hit;

  // form the PGN; PDU1 frames drop the PS byte
  assign pf  = frame_id[23:16];
  assign ps  = frame_id[15:8];
  assign pgn = (pf < jefd_pkg::PF_PDU2_MIN) ? {pf, 8'h00} : {pf, ps};

  // match in register order, first hit wins
  always_comb begin
    hit    = 1'b1;
    cmd.op = jefd_pkg::OP_SPEED;
    if (pgn == pgn_cfg.engine_ctrl) begin
      cmd.op = jefd_pkg::OP_SPEED;
    end else if (pgn == pgn_cfg.engine_temp) begin
      cmd.op = jefd_pkg::OP_TEMP;
    end else if (pgn == pgn_cfg.fluid_press) begin
      cmd.op = jefd_pkg::OP_PRESS;
    end else if (pgn == pgn_cfg.diag_active) begin
      cmd.op = jefd_pkg::OP_DIAG;
    end else if (pgn == pgn_cfg.vehicle_power) begin
      cmd.op = jefd_pkg::OP_POWER;
    end else if (pgn == pgn_cfg.engine_hours) begin
      cmd.op = jefd_pkg::OP_HOURS;
    end else begin
      hit = 1'b0;
    end
  end

  // carry the payload bytes the back needs
  assign cmd.b0 = byte0;
  assign cmd.b1 = byte1;
  assign cmd.b2 = byte2;
  assign cmd.b3 = byte3;
  assign cmd.b4 = byte4;
  assign cmd.b5 = byte5;

  // drop unmatched frames here
  assign q_push = accept && hit;

endmodule

>>> design/jefd_cmd_queue.sv
// ----------------------------------------------------------------------------
// J1939 decoder command queue
// Short FIFO of classified frames between the front and the back.
// ----------------------------------------------------------------------------
module jefd_cmd_queue #(
  parameter int DEPTH = jefd_pkg::CMD_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  jefd_pkg::cmd_t       wdata,
  input  logic                 pop,
  output jefd_pkg::cmd_t       rdata,
  output jefd_pkg::cq_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jefd_pkg::cmd_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status.full     = (count == CNT_W'(DEPTH));
  assign status.nonempty = (count != '0);
  assign rdata           = mem[rd_ptr];

  // store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

>>> design/jefd_back.sv
// ----------------------------------------------------------------------------
// J1939 decoder executor
// Checks readings against stored values and step limits, builds results.
// ----------------------------------------------------------------------------
module jefd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  jefd_pkg::cmd_t       cmd,
  input  logic                 room_two,
  input  jefd_pkg::limit_cfg_t limits,
  output logic                 cmd_pop,
  output jefd_pkg::res_push_t  res_push
);

  // stored readings
  logic [15:0] speed;
  logic [7:0]  coolant;
  logic [15:0] oil_temp;
  logic [7:0]  oil_pres;
  logic [15:0] battery;
  logic [31:0] hours;
  logic        fault_flag;

  logic        go;
  logic [15:0] v_speed;
  logic [15:0] v_oil;
  logic [15:0] v_batt;
  logic [31:0] v_hours;
  logic        ok_speed;
  logic        ok_cool;
  logic        ok_oil;
  logic        ok_pres;
  logic        ok_batt;
  logic        ok_hours;
  logic [18:0] spn;
  logic        seen_next;

  function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

  function automatic jefd_pkg::res_t sensor_res(input logic [2:0] sid,
                                                input logic [31:0] value,
                                                input logic fin);
    jefd_pkg::res_t r;
    r           = '0;
    r.kind      = jefd_pkg::KIND_SENSOR;
    r.sensor_id = sid;
    r.reading   = value;
    r.last      = fin;
    return r;
  endfunction

  // take a command only when two result slots are free
  assign go      = cmd_valid && room_two;
  assign cmd_pop = go;

  // extract little-endian readings
  assign v_speed = {cmd.b4, cmd.b3};
  assign v_oil   = {cmd.b3, cmd.b2};
  assign v_batt  = {cmd.b5, cmd.b4};
  assign v_hours = {cmd.b3, cmd.b2, cmd.b1, cmd.b0};

  // change and step checks
  assign ok_speed = (v_speed != speed) && (abs_diff(v_speed, speed) < limits.speed);
  assign ok_cool  = (cmd.b0 != coolant);
  assign ok_oil   = (v_oil != oil_temp) && (abs_diff(v_oil, oil_temp) < limits.oil_temp);
  assign ok_pres  = (cmd.b3 != oil_pres);
  assign ok_batt  = (v_batt != battery);
  assign ok_hours = (v_hours != hours);

  // trouble code fields; byte 3 and byte 2 overlap in bits 11 and 12
  assign spn       = {cmd.b3, 11'h000} | {6'h00, cmd.b2, 5'h00} | {16'h0000, cmd.b4[7:5]};
  assign seen_next = fault_flag || (spn != '0);

  // build results for this command
  always_comb begin
    res_push = '0;
    if (go) begin
      unique case (cmd.op)
        jefd_pkg::OP_SPEED: begin
          if (ok_speed) begin
            res_push.n     = 2'd1;
            res_push.first = sensor_res(jefd_pkg::SID_SPEED, {16'h0000, v_speed}, 1'b1);
          end
        end
        jefd_pkg::OP_TEMP: begin
          if (ok_cool && ok_oil) begin
            res_push.n      = 2'd2;
            res_push.first  = sensor_res(jefd_pkg::SID_COOLANT, {24'h000000, cmd.b0}, 1'b0);
            res_push.second = sensor_res(jefd_pkg::SID_OIL_TEMP, {16'h0000, v_oil}, 1'b1);
          end else if (ok_cool) begin
            res_push.n     = 2'd1;
            res_push.first = sensor_res(jefd_pkg::SID_COOLANT, {24'h000000, cmd.b0}, 1'b1);
          end else if (ok_oil) begin
            res_push.n     = 2'd1;
            res_push.first = sensor_res(jefd_pkg::SID_OIL_TEMP, {16'h0000, v_oil}, 1'b1);
          end
        end
        jefd_pkg::OP_PRESS: begin
          if (ok_pres) begin
            res_push.n     = 2'd1;
            res_push.first = sensor_res(jefd_pkg::SID_OIL_PRES, {24'h000000, cmd.b3}, 1'b1);
          end
        end
        jefd_pkg::OP_DIAG: begin
          res_push.n                 = 2'd1;
          res_push.first.kind        = jefd_pkg::KIND_CODE;
          res_push.first.fault_spn   = spn;
          res_push.first.fault_fmi   = cmd.b4[4:0];
          res_push.first.fault_count = cmd.b5[6:0];
          res_push.first.fault_seen  = seen_next;
          res_push.first.last        = 1'b1;
        end
        jefd_pkg::OP_POWER: begin
          if (ok_batt) begin
            res_push.n     = 2'd1;
            res_push.first = sensor_res(jefd_pkg::SID_BATTERY, {16'h0000, v_batt}, 1'b1);
          end
        end
        jefd_pkg::OP_HOURS: begin
          if (ok_hours) begin
            res_push.n     = 2'd1;
            res_push.first = sensor_res(jefd_pkg::SID_HOURS, v_hours, 1'b1);
          end
        end
        default: begin
          res_push = '0;
        end
      endcase
    end
  end

  // update stored readings and the sticky fault flag
  always_ff @(posedge clk) begin
    if (rst) begin
      speed      <= '0;
      coolant    <= '0;
      oil_temp   <= '0;
      oil_pres   <= '0;
      battery    <= '0;
      hours      <= '0;
      fault_flag <= 1'b0;
    end else if (go) begin
      if (cmd.op == jefd_pkg::OP_SPEED && ok_speed) begin
        speed <= v_speed;
      end
      if (cmd.op == jefd_pkg::OP_TEMP && ok_cool) begin
        coolant <= cmd.b0;
      end
      if (cmd.op == jefd_pkg::OP_TEMP && ok_oil) begin
        oil_temp <= v_oil;
      end
      if (cmd.op == jefd_pkg::OP_PRESS && ok_pres) begin
        oil_pres <= cmd.b3;
      end
      if (cmd.op == jefd_pkg::OP_POWER && ok_batt) begin
        battery <= v_batt;
      end
      if (cmd.op == jefd_pkg::OP_HOURS && ok_hours) begin
        hours <= v_hours;
      end
      if (cmd.op == jefd_pkg::OP_DIAG) begin
        fault_flag <= seen_next;
      end
    end
  end

endmodule

>>> design/jefd_result_queue.sv
// ----------------------------------------------------------------------------
// J1939 decoder result queue
// FIFO of result items; takes up to two items per cycle, gives one.
// ----------------------------------------------------------------------------
module jefd_result_queue #(
  parameter int DEPTH = jefd_pkg::RES_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  jefd_pkg::res_push_t  res_push,
  input  logic                 pop,
  output jefd_pkg::res_t       head,
  output jefd_pkg::rq_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jefd_pkg::res_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_b;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_b        = ptr_inc(wr_ptr);
  assign head            = mem[rd_ptr];
  assign status.nonempty = (count != '0);
  assign status.room_two = (count <= CNT_W'(DEPTH - 2));

  // store one or two items
  always_ff @(posedge clk) begin
    if (res_push.n != 2'd0) begin
      mem[wr_ptr] <= res_push.first;
    end
    if (res_push.n == 2'd2) begin
      mem[wr_ptr_b] <= res_push.second;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_push.n == 2'd1) begin
        wr_ptr <= wr_ptr_b;
      end else if (res_push.n == 2'd2) begin
        wr_ptr <= ptr_inc(wr_ptr_b);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CNT_W'(res_push.n) - CNT_W'(pop);
    end
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// J1939 engine frame decoder testbench
// Sends extended CAN frames through the queue-style input and checks every
// popped result against an in-bench decoder that tracks the same sensor
// store, sticky fault flag and match registers. The run covers directed
// corner frames, PDU1 and overlapping PGN set-ups, step limits at their
// extremes and several phases of random traffic under varied back-pressure.
// ----------------------------------------------------------------------------
module tb;

  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 280;

  // one frame as seen on the input ports, data[0] is byte 0
  typedef struct packed {
    logic [28:0]     id;
    logic [7:0][7:0] data;
  } frame_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [28:0] frame_id = '0;
  logic [7:0]  byte0 = '0, byte1 = '0, byte2 = '0, byte3 = '0;
  logic [7:0]  byte4 = '0, byte5 = '0, byte6 = '0, byte7 = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind;
  logic [2:0]  sensor_id;
  logic [31:0] reading;
  logic [18:0] fault_spn;
  logic [4:0]  fault_fmi;
  logic [6:0]  fault_count;
  logic        fault_seen;
  logic        last;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [jefd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                    cfg_data = '0;

  // decoder copy: match registers, limits, sensor store and fault flag
  logic [15:0] pgn_reg [6];
  logic [15:0] speed_limit;
  logic [15:0] oil_limit;
  logic [31:0] sensor_val [6];
  logic        fault_flag;

  jefd_pkg::res_t new_res [2];
  int             n_new;
  jefd_pkg::res_t due_results [$];

  int mismatch_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  j1939_engine_frame_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .frame_id    (frame_id),
    .byte0       (byte0),
    .byte1       (byte1),
    .byte2       (byte2),
    .byte3       (byte3),
    .byte4       (byte4),
    .byte5       (byte5),
    .byte6       (byte6),
    .byte7       (byte7),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .sensor_id   (sensor_id),
    .reading     (reading),
    .fault_spn   (fault_spn),
    .fault_fmi   (fault_fmi),
    .fault_count (fault_count),
    .fault_seen  (fault_seen),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- decoder

  function automatic logic [15:0] frame_pgn(input logic [28:0] id);
    logic [7:0] pf;
    logic [7:0] ps;
    pf = id[23:16];
    ps = id[15:8];
    // PDU1 frames drop the destination byte
    if (pf < jefd_pkg::PF_PDU2_MIN)
      return {pf, 8'h00};
    return {pf, ps};
  endfunction

  task automatic reset_model();
    pgn_reg[jefd_pkg::REG_PGN_ENGINE_CTRL]   = jefd_pkg::PGN_ENGINE_CTRL_RST;
    pgn_reg[jefd_pkg::REG_PGN_ENGINE_TEMP]   = jefd_pkg::PGN_ENGINE_TEMP_RST;
    pgn_reg[jefd_pkg::REG_PGN_FLUID_PRESS]   = jefd_pkg::PGN_FLUID_PRESS_RST;
    pgn_reg[jefd_pkg::REG_PGN_DIAG_ACTIVE]   = jefd_pkg::PGN_DIAG_ACTIVE_RST;
    pgn_reg[jefd_pkg::REG_PGN_VEHICLE_POWER] = jefd_pkg::PGN_VEHICLE_POWER_RST;
    pgn_reg[jefd_pkg::REG_PGN_ENGINE_HOURS]  = jefd_pkg::PGN_ENGINE_HOURS_RST;
    speed_limit = jefd_pkg::SPEED_STEP_LIMIT_RST;
    oil_limit   = jefd_pkg::OIL_TEMP_STEP_LIMIT_RST;
    for (int i = 0; i < 6; i++)
      sensor_val[i] = '0;
    fault_flag = 1'b0;
  endtask

  // accept a reading if it changed and passes the step check
  task automatic offer_reading(input logic [2:0] sid, input logic [31:0] value);
    logic [31:0]    old;
    logic [31:0]    diff;
    jefd_pkg::res_t upd;
    old = sensor_val[sid];
    if (value == old)
      return;
    diff = (value > old) ? value - old : old - value;
    if (sid == jefd_pkg::SID_SPEED && diff >= {16'h0, speed_limit})
      return;
    if (sid == jefd_pkg::SID_OIL_TEMP && diff >= {16'h0, oil_limit})
      return;
    sensor_val[sid] = value;
    upd = '0;
    upd.kind = jefd_pkg::KIND_SENSOR;
    upd.sensor_id = sid;
    upd.reading = value;
    new_res[n_new] = upd;
    n_new++;
  endtask

  task automatic decode_frame(input frame_t f);
    logic [15:0]    pgn;
    logic [18:0]    spn;
    jefd_pkg::res_t code;
    int             hit;
    pgn = frame_pgn(f.id);
    hit = -1;
    n_new = 0;
    // lowest register index wins on overlap
    for (int r = 5; r >= 0; r--)
      if (pgn == pgn_reg[r])
        hit = r;
    case (hit)
      jefd_pkg::REG_PGN_ENGINE_CTRL:
        offer_reading(jefd_pkg::SID_SPEED, {16'h0, f.data[4], f.data[3]});
      jefd_pkg::REG_PGN_ENGINE_TEMP: begin
        offer_reading(jefd_pkg::SID_COOLANT, {24'h0, f.data[0]});
        offer_reading(jefd_pkg::SID_OIL_TEMP, {16'h0, f.data[3], f.data[2]});
      end
      jefd_pkg::REG_PGN_FLUID_PRESS:
        offer_reading(jefd_pkg::SID_OIL_PRES, {24'h0, f.data[3]});
      jefd_pkg::REG_PGN_DIAG_ACTIVE: begin
        // byte 3 and byte 2 fields overlap in bits 11 and 12
        spn = (19'(f.data[3]) << 11) | (19'(f.data[2]) << 5) | 19'(f.data[4][7:5]);
        if (spn != '0)
          fault_flag = 1'b1;
        code = '0;
        code.kind = jefd_pkg::KIND_CODE;
        code.fault_spn = spn;
        code.fault_fmi = f.data[4][4:0];
        code.fault_count = f.data[5][6:0];
        code.fault_seen = fault_flag;
        new_res[0] = code;
        n_new = 1;
      end
      jefd_pkg::REG_PGN_VEHICLE_POWER:
        offer_reading(jefd_pkg::SID_BATTERY, {16'h0, f.data[5], f.data[4]});
      jefd_pkg::REG_PGN_ENGINE_HOURS:
        offer_reading(jefd_pkg::SID_HOURS, {f.data[3], f.data[2], f.data[1], f.data[0]});
      default: ;
    endcase
    if (n_new > 0)
      new_res[n_new-1].last = 1'b1;
    for (int i = 0; i < n_new; i++)
      due_results.push_back(new_res[i]);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each popped item with the oldest expectation
  always @(posedge clk) begin
    jefd_pkg::res_t want;
    if (!rst && pop && !empty) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual sensor %0d reading %0h",
                 $time, sensor_id, reading);
        mismatch_count++;
      end else begin
        want = due_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind));
        check_field("sensor_id", 32'(want.sensor_id), 32'(sensor_id));
        check_field("reading", want.reading, reading);
        check_field("fault_spn", 32'(want.fault_spn), 32'(fault_spn));
        check_field("fault_fmi", 32'(want.fault_fmi), 32'(fault_fmi));
        check_field("fault_count", 32'(want.fault_count), 32'(fault_count));
        check_field("fault_seen", 32'(want.fault_seen), 32'(fault_seen));
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  // stall the result side at the current rate
  always @(negedge clk)
    pop <= ($urandom_range(99) >= recv_stall_pct);

  // count cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- driving

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // present one item, hold it until taken, then predict its results
  task automatic send_frame(input frame_t f);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    frame_id = f.id;
    byte0 = f.data[0];
    byte1 = f.data[1];
    byte2 = f.data[2];
    byte3 = f.data[3];
    byte4 = f.data[4];
    byte5 = f.data[5];
    byte6 = f.data[6];
    byte7 = f.data[7];
    push = 1'b1;
    @(posedge clk);
    while (full)
      @(posedge clk);
    decode_frame(f);
  endtask

  // hold the input until every expected item has been popped
  task automatic drain_results();
    @(negedge clk);
    push = 1'b0;
    while (due_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // call only after drain_results, on a falling edge
  task automatic write_reg(input logic [jefd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] value);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    case (idx)
      jefd_pkg::REG_SPEED_STEP_LIMIT:    speed_limit = value;
      jefd_pkg::REG_OIL_TEMP_STEP_LIMIT: oil_limit = value;
      default:                           pgn_reg[idx] = value;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_config(input logic [15:0] ctrl, input logic [15:0] temp,
                             input logic [15:0] press, input logic [15:0] diag,
                             input logic [15:0] power, input logic [15:0] hours,
                             input logic [15:0] spd_lim, input logic [15:0] oil_lim);
    write_reg(jefd_pkg::REG_PGN_ENGINE_CTRL, ctrl);
    write_reg(jefd_pkg::REG_PGN_ENGINE_TEMP, temp);
    write_reg(jefd_pkg::REG_PGN_FLUID_PRESS, press);
    write_reg(jefd_pkg::REG_PGN_DIAG_ACTIVE, diag);
    write_reg(jefd_pkg::REG_PGN_VEHICLE_POWER, power);
    write_reg(jefd_pkg::REG_PGN_ENGINE_HOURS, hours);
    write_reg(jefd_pkg::REG_SPEED_STEP_LIMIT, spd_lim);
    write_reg(jefd_pkg::REG_OIL_TEMP_STEP_LIMIT, oil_lim);
  endtask

  task automatic load_defaults(input logic [15:0] spd_lim, input logic [15:0] oil_lim);
    load_config(jefd_pkg::PGN_ENGINE_CTRL_RST, jefd_pkg::PGN_ENGINE_TEMP_RST,
                jefd_pkg::PGN_FLUID_PRESS_RST, jefd_pkg::PGN_DIAG_ACTIVE_RST,
                jefd_pkg::PGN_VEHICLE_POWER_RST, jefd_pkg::PGN_ENGINE_HOURS_RST,
                spd_lim, oil_lim);
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic frame_t make_frame(input logic [28:0] id, input logic [63:0] data);
    frame_t f;
    f.id = id;
    f.data = data;
    return f;
  endfunction

  // random priority and source around a PGN; random PS for PDU1
  function automatic logic [28:0] frame_id_for(input logic [15:0] pgn);
    logic [28:0] id;
    id = 29'($urandom);
    id[23:16] = pgn[15:8];
    if (pgn[15:8] >= jefd_pkg::PF_PDU2_MIN)
      id[15:8] = pgn[7:0];
    return id;
  endfunction

  // reading close to the stored one, often right at the step limit
  function automatic logic [15:0] near_reading(input logic [15:0] old,
                                               input logic [15:0] lim);
    logic [15:0] step;
    case ($urandom_range(5))
      0:       step = 16'd0;
      1:       step = lim - 16'd1;
      2:       step = lim;
      3:       step = 16'($urandom_range(8));
      4:       step = 16'd1;
      default: return 16'($urandom);
    endcase
    return $urandom_range(1) ? old + step : old - step;
  endfunction

  function automatic frame_t random_frame();
    frame_t      f;
    int unsigned pick;
    f.id = 29'($urandom);
    f.data = {$urandom, $urandom};
    // noise: mostly unmatched identifiers
    if ($urandom_range(99) < 12)
      return f;
    pick = $urandom_range(5);
    f.id = frame_id_for(pgn_reg[pick]);
    case (pick)
      jefd_pkg::REG_PGN_ENGINE_CTRL:
        {f.data[4], f.data[3]} =
          near_reading(sensor_val[jefd_pkg::SID_SPEED][15:0], speed_limit);
      jefd_pkg::REG_PGN_ENGINE_TEMP: begin
        if ($urandom_range(2) == 0)
          f.data[0] = sensor_val[jefd_pkg::SID_COOLANT][7:0];
        {f.data[3], f.data[2]} =
          near_reading(sensor_val[jefd_pkg::SID_OIL_TEMP][15:0], oil_limit);
      end
      jefd_pkg::REG_PGN_FLUID_PRESS:
        if ($urandom_range(2) == 0)
          f.data[3] = sensor_val[jefd_pkg::SID_OIL_PRES][7:0];
      jefd_pkg::REG_PGN_DIAG_ACTIVE:
        if ($urandom_range(4) == 0) begin
          f.data[2] = 8'h00;
          f.data[3] = 8'h00;
          f.data[4][7:5] = 3'b000;
        end
      jefd_pkg::REG_PGN_VEHICLE_POWER:
        if ($urandom_range(3) == 0)
          {f.data[5], f.data[4]} = sensor_val[jefd_pkg::SID_BATTERY][15:0];
      default:
        case ($urandom_range(2))
          0: {f.data[3], f.data[2], f.data[1], f.data[0]} = sensor_val[jefd_pkg::SID_HOURS];
          1: {f.data[3], f.data[2], f.data[1], f.data[0]} =
               sensor_val[jefd_pkg::SID_HOURS] + $urandom_range(1, 3);
          default: ;
        endcase
    endcase
    return f;
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_frame(random_frame());
  endtask

  // ---------------------------------------------------------------- tests

  // corner frames with the reset set-up
  task automatic test_directed_cases();
    set_idling(0, 0);
    // speed: unchanged, just under the limit, at the limit, back down
    send_frame(make_frame(frame_id_for(jefd_pkg::PGN_ENGINE_CTRL_RST),
                          {24'hFFFFFF, 16'd0, 24'hFFFFFF}));
    send_frame(make_frame(frame_id_for(jefd_pkg::PGN_ENGINE_CTRL_RST),
                          {24'h0, 16'd5999, 24'h0}));
    send_frame(make_frame(frame_id_for(jefd_pkg::PGN_ENGINE_CTRL_RST),
                          {24'h0, 16'd11999, 24'h0}));
    send_frame(make_frame(frame_id_for(jefd_pkg::PGN_ENGINE_CTRL_RST),
                          {24'h0, 16'd0, 24'h0}));
    // temperature: both change, oil step rejected, coolant alone
    send_frame(make_frame(frame_id_for(jefd_pkg::PGN_ENGINE_TEMP_RST),
                          {32'h0, 16'd159, 8'h00, 8'hFF}));
    send_frame(make_frame(frame_id_for(jefd_pkg::PGN_ENGINE_TEMP_RST),
                          {32'hFFFFFFFF, 16'd319, 8'hFF, 8'hFF}));
    send_frame(make_frame(frame_id_for(jefd_pkg::PGN_ENGINE_TEMP_RST),
                          {32'h0, 16'd159, 8'h00, 8'h00}));
    send_frame(make_frame(frame_id_for(jefd_pkg::PGN_FLUID_PRESS_RST),
                          {32'h0, 8'hFF, 24'h0}));
    // trouble codes: zero SPN, full SPN, zero again with the flag held
    send_frame(make_frame(frame_id_for(jefd_pkg::PGN_DIAG_ACTIVE_RST),
                          {16'h0, 8'hFF, 8'h1F, 8'h00, 8'h00, 16'h0}));
    send_frame(make_frame(frame_id_for(jefd_pkg::PGN_DIAG_ACTIVE_RST),
                          {16'hFFFF, 8'h80, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF}));
    send_frame(make_frame(frame_id_for(jefd_pkg::PGN_DIAG_ACTIVE_RST), 64'h0));
    send_frame(make_frame(frame_id_for(jefd_pkg::PGN_VEHICLE_POWER_RST),
                          {16'h0, 16'hFFFF, 32'h0}));
    send_frame(make_frame(frame_id_for(jefd_pkg::PGN_ENGINE_HOURS_RST),
                          {32'h0, 32'hFFFFFFFF}));
    send_frame(make_frame(frame_id_for(jefd_pkg::PGN_ENGINE_HOURS_RST), 64'h0));
    // unmatched identifiers at both extremes and a PDU1 frame
    send_frame(make_frame(29'h1FFFFFFF, 64'hFFFFFFFFFFFFFFFF));
    send_frame(make_frame(29'h0, 64'h0));
    send_frame(make_frame({5'h00, 8'hEF, 8'hFF, 8'h00}, 64'h0123456789ABCDEF));
    // priority and source bits all set on a matching frame
    send_frame(make_frame({5'h1F, 8'hF0, 8'h04, 8'hFF}, {24'h0, 16'd100, 24'h0}));
  endtask

  // PDU1 match values, the PF boundary and registers that share a PGN
  task automatic test_pdu1_and_overlap();
    set_idling(28, 28);
    drain_results();
    load_config(16'h0000, 16'hEF00, 16'hFFFF, 16'hEF00, 16'h1234, 16'hF0FF, 16'd6000,
                16'd160);
    send_frame(make_frame({5'h0A, 8'h00, 8'hAB, 8'h12}, {24'h0, 16'd1234, 24'h0}));
    send_frame(make_frame({5'h15, 8'hEF, 8'h55, 8'hA5}, {32'h0, 16'd200, 8'h00, 8'h42}));
    send_frame(make_frame({5'h1F, 8'hFF, 8'hFF, 8'hFF}, {32'h0, 8'h10, 24'h0}));
    send_frame(make_frame({5'h00, 8'hF0, 8'hFF, 8'h00}, {32'h0, 32'h12345678}));
    send_frame(make_frame({5'h03, 8'h12, 8'h34, 8'h56}, {16'h0, 16'h4321, 32'h0}));
    send_random(30);
    // every register on one PGN: speed always wins
    drain_results();
    load_config(16'hFECA, 16'hFECA, 16'hFECA, 16'hFECA, 16'hFECA, 16'hFECA, 16'd6000,
                16'd160);
    send_random(10);
  endtask

  // limits of zero, one and full scale
  task automatic test_step_limits();
    set_idling(28, 28);
    drain_results();
    load_defaults(16'd0, 16'd0);
    send_random(20);
    drain_results();
    write_reg(jefd_pkg::REG_SPEED_STEP_LIMIT, 16'd1);
    write_reg(jefd_pkg::REG_OIL_TEMP_STEP_LIMIT, 16'd1);
    send_random(20);
    drain_results();
    write_reg(jefd_pkg::REG_SPEED_STEP_LIMIT, 16'hFFFF);
    write_reg(jefd_pkg::REG_OIL_TEMP_STEP_LIMIT, 16'hFFFF);
    send_random(20);
  endtask

  // long random phases, one idling pattern and set-up each
  task automatic test_random_traffic();
    logic [15:0] pgn [6];
    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: begin
          set_idling(0, 0);
          load_defaults(jefd_pkg::SPEED_STEP_LIMIT_RST, jefd_pkg::OIL_TEMP_STEP_LIMIT_RST);
        end
        1: begin
          set_idling(75, 0);
          load_defaults(16'($urandom_range(1, 20000)), 16'($urandom_range(1, 400)));
        end
        2: begin
          set_idling(0, 75);
          // random PGNs, kept reachable for PDU1 values
          for (int r = 0; r < 6; r++) begin
            pgn[r] = 16'($urandom);
            if (pgn[r][15:8] < jefd_pkg::PF_PDU2_MIN)
              pgn[r][7:0] = 8'h00;
          end
          load_config(pgn[0], pgn[1], pgn[2], pgn[3], pgn[4], pgn[5],
                      jefd_pkg::SPEED_STEP_LIMIT_RST, jefd_pkg::OIL_TEMP_STEP_LIMIT_RST);
        end
        default: begin
          set_idling(28, 28);
          load_defaults(16'hFFFF, 16'hFFFF);
        end
      endcase
      send_random(PHASE_ITEMS / 2);
      // hold off the sender until the result side is empty
      drain_results();
      send_random(PHASE_ITEMS / 2);
    end
  endtask

  initial begin
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_cases();
    test_pdu1_and_overlap();
    test_step_limits();
    test_random_traffic();
    set_idling(0, 0);
    drain_results();
    if (mismatch_count == 0 && due_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/jefd_pkg.sv
design/jefd_front.sv
design/jefd_cmd_queue.sv
design/jefd_back.sv
design/jefd_result_queue.sv
design/j1939_engine_frame_decoder.sv
sim/tb.sv
